// File: src/srfo_pkg.sv
// ----------------------------------------------------------------------------
// srfo_pkg: shared types and constants of the shape rasterizer
// Command record between front and back, opcode/shape/status codes and
// back-end state encoding.
// ----------------------------------------------------------------------------
package srfo_pkg;

   // default canvas geometry
   localparam int CANVAS_WIDTH_DEF  = 64;
   localparam int CANVAS_HEIGHT_DEF = 64;

   // field widths
   localparam int COORD_W  = 7;     // canvas coordinate, up to 128 columns/rows
   localparam int EDGE_W   = 10;    // signed shape edge before clipping
   localparam int POS_W    = 8;
   localparam int SIZE_W   = 7;
   localparam int COLOR_W  = 8;
   localparam int DIST_W   = 14;    // r*r + r and squared offsets
   localparam int PIXEL_W  = 3 * COLOR_W + 1;
   localparam int REQ_DATA_W  = 56;
   localparam int REQ_USER_W  = 4;
   localparam int RSP_DATA_W  = 32;
   localparam int RSP_USER_W  = 2;

   localparam int QUEUE_DEPTH = 2;

   // opcodes
   localparam logic OP_DRAW = 1'b0;
   localparam logic OP_READ = 1'b1;

   // shape kinds
   localparam logic [1:0] SHAPE_SQUARE = 2'd0;
   localparam logic [1:0] SHAPE_RECT   = 2'd1;
   localparam logic [1:0] SHAPE_CIRCLE = 2'd2;
   localparam logic [1:0] SHAPE_NONE   = 2'd3;

   // response status
   localparam logic [1:0] STAT_DRAW    = 2'd0;
   localparam logic [1:0] STAT_READ    = 2'd1;
   localparam logic [1:0] STAT_OUTSIDE = 2'd2;

   // classified command, one queue entry
   typedef struct packed {
      logic                     is_read;
      logic                     circle;
      logic                     outline;
      logic                     empty;     // nothing to draw, or read off canvas
      logic [COORD_W-1:0]       x_lo;
      logic [COORD_W-1:0]       x_hi;
      logic [COORD_W-1:0]       y_lo;
      logic [COORD_W-1:0]       y_hi;
      logic signed [EDGE_W-1:0] xa;        // unclipped box edges
      logic signed [EDGE_W-1:0] xb;
      logic signed [EDGE_W-1:0] ya;
      logic signed [EDGE_W-1:0] yb;
      logic signed [POS_W-1:0]  cx;        // circle center
      logic signed [POS_W-1:0]  cy;
      logic [DIST_W-1:0]        d2_hi;
      logic [DIST_W-1:0]        d2_lo;
      logic [COLOR_W-1:0]       red;
      logic [COLOR_W-1:0]       green;
      logic [COLOR_W-1:0]       blue;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_FLUSH,
      ST_RD_ADDR,
      ST_RD_MEM,
      ST_DONE
   } back_state_type;

endpackage

// File: src/srfo_front.sv
// ----------------------------------------------------------------------------
// srfo_front: request intake and classification
// Unpacks a request, computes the shape's bounding box, clips it to the
// canvas and precomputes the circle distance window.
// ----------------------------------------------------------------------------
module srfo_front
   import srfo_pkg::*;
#(
   parameter int CANVAS_WIDTH  = CANVAS_WIDTH_DEF,
   parameter int CANVAS_HEIGHT = CANVAS_HEIGHT_DEF
) (
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [REQ_USER_W-1:0] req_tuser,
   input  logic                  clearing,
   input  logic                  q_ready,
   output logic                  q_push,
   output cmd_type               q_entry
);

   localparam logic signed [EDGE_W-1:0] XMAX = EDGE_W'(CANVAS_WIDTH - 1);
   localparam logic signed [EDGE_W-1:0] YMAX = EDGE_W'(CANVAS_HEIGHT - 1);

   logic                     opcode;
   logic [1:0]               shape_kind;
   logic                     outline_only;
   logic signed [POS_W-1:0]  pos_x;
   logic signed [POS_W-1:0]  pos_y;
   logic [SIZE_W-1:0]        size_a;
   logic [SIZE_W-1:0]        size_b;
   logic signed [EDGE_W-1:0] px, py, ra, rh;
   logic signed [EDGE_W-1:0] xa, xb, ya, yb, xl, xh, yl, yh;
   logic                     empty;
   logic [DIST_W-1:0]        r_sq;

   // field unpacking
   assign opcode       = req_tuser[0];
   assign shape_kind   = req_tuser[2:1];
   assign outline_only = req_tuser[3];
   assign pos_x        = req_tdata[7:0];
   assign pos_y        = req_tdata[15:8];
   assign size_a       = req_tdata[22:16];
   assign size_b       = req_tdata[29:23];

   // handshake: nothing taken while the canvas is being cleared
   assign req_tready = !clearing && q_ready;
   assign q_push     = req_tvalid && req_tready;

   assign px   = {{(EDGE_W-POS_W){pos_x[POS_W-1]}}, pos_x};
   assign py   = {{(EDGE_W-POS_W){pos_y[POS_W-1]}}, pos_y};
   assign ra   = {{(EDGE_W-SIZE_W){1'b0}}, size_a};
   assign rh   = (shape_kind == SHAPE_RECT) ? {{(EDGE_W-SIZE_W){1'b0}}, size_b} : ra;
   assign r_sq = {{(DIST_W-SIZE_W){1'b0}}, size_a} * {{(DIST_W-SIZE_W){1'b0}}, size_a};

   // bounding box and clipping
   always_comb begin
      if (opcode == OP_READ) begin
         xa = px;
         xb = px;
         ya = py;
         yb = py;
      end else if (shape_kind == SHAPE_CIRCLE) begin
         xa = px - ra;
         xb = px + ra;
         ya = py - ra;
         yb = py + ra;
      end else begin
         xa = px;
         xb = px + ra - EDGE_W'(1);
         ya = py;
         yb = py + rh - EDGE_W'(1);
      end
      empty = ((opcode == OP_DRAW) && (shape_kind == SHAPE_NONE)) ||
              (xb < xa) || (yb < ya) || xb[EDGE_W-1] || yb[EDGE_W-1] ||
              (xa > XMAX) || (ya > YMAX);
      xl = xa[EDGE_W-1] ? '0 : xa;
      yl = ya[EDGE_W-1] ? '0 : ya;
      xh = (xb > XMAX) ? XMAX : xb;
      yh = (yb > YMAX) ? YMAX : yb;
   end

   // queue entry
   always_comb begin
      q_entry.is_read = (opcode == OP_READ);
      q_entry.circle  = (shape_kind == SHAPE_CIRCLE);
      q_entry.outline = outline_only;
      q_entry.empty   = empty;
      q_entry.x_lo    = xl[COORD_W-1:0];
      q_entry.x_hi    = xh[COORD_W-1:0];
      q_entry.y_lo    = yl[COORD_W-1:0];
      q_entry.y_hi    = yh[COORD_W-1:0];
      q_entry.xa      = xa;
      q_entry.xb      = xb;
      q_entry.ya      = ya;
      q_entry.yb      = yb;
      q_entry.cx      = pos_x;
      q_entry.cy      = pos_y;
      q_entry.d2_hi   = r_sq + {{(DIST_W-SIZE_W){1'b0}}, size_a};
      q_entry.d2_lo   = (outline_only && (size_a != '0)) ?
                        r_sq - {{(DIST_W-SIZE_W){1'b0}}, size_a} + DIST_W'(1) : '0;
      q_entry.red     = req_tdata[37:30];
      q_entry.green   = req_tdata[45:38];
      q_entry.blue    = req_tdata[53:46];
   end

endmodule

// File: src/srfo_queue.sv
// ----------------------------------------------------------------------------
// srfo_queue: short command queue between front and back
// Holds classified commands so intake and rasterizing stall independently.
// ----------------------------------------------------------------------------
module srfo_queue
   import srfo_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_entry,
   output logic    in_ready,
   input  logic    pop,
   output cmd_type pop_entry,
   output logic    out_valid
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign in_ready  = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign pop_entry = entry_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: src/srfo_back.sv
// ----------------------------------------------------------------------------
// srfo_back: rasterizer, canvas memory and response register
// Walks the clipped bounding box one pixel a cycle, tests coverage in a
// registered stage, writes the canvas, serves pixel reads.
// ----------------------------------------------------------------------------
module srfo_back
   import srfo_pkg::*;
#(
   parameter int CANVAS_WIDTH  = CANVAS_WIDTH_DEF,
   parameter int CANVAS_HEIGHT = CANVAS_HEIGHT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  cmd_type               q_entry,
   output logic                  q_pop,
   output logic                  clearing,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [RSP_USER_W-1:0] rsp_tuser
);

   localparam int DEPTH = CANVAS_WIDTH * CANVAS_HEIGHT;
   localparam int AW    = $clog2(DEPTH);

   back_state_type        state_ff, state_in;
   cmd_type               cmd_ff;
   logic [COORD_W-1:0]    x_ff, y_ff;
   logic [AW-1:0]         clr_ff;
   logic [AW-1:0]         addr_c;
   logic                  walk_step;
   logic                  load_rsp;

   // coverage stage
   logic                  p1_vld_ff;
   logic [AW-1:0]         p1_addr_ff;
   logic [DIST_W-1:0]     p1_dx2_ff, p1_dy2_ff;
   logic                  p1_edge_ff;

   logic signed [EDGE_W-1:0] xs, ys, di, dj;
   logic [SIZE_W-1:0]     adx, ady;
   logic [DIST_W:0]       d2;
   logic                  hit;

   // canvas memory: {mark, blue, green, red}
   logic [PIXEL_W-1:0]    canvas_ff [DEPTH];
   logic [PIXEL_W-1:0]    rdata_ff;
   logic                  mem_we;
   logic [AW-1:0]         mem_waddr;
   logic [PIXEL_W-1:0]    mem_wdata;

   logic                  rsp_valid_ff;
   logic [1:0]            rsp_status_ff;
   logic [PIXEL_W-1:0]    rsp_pixel_ff;

   assign clearing = (state_ff == ST_CLEAR);

   // next state and control
   always_comb begin
      state_in  = state_ff;
      q_pop     = 1'b0;
      walk_step = 1'b0;
      load_rsp  = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_entry.empty) begin
                  state_in = ST_DONE;
               end else if (q_entry.is_read) begin
                  state_in = ST_RD_ADDR;
               end else begin
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            walk_step = 1'b1;
            if ((x_ff == cmd_ff.x_hi) && (y_ff == cmd_ff.y_hi)) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH:   state_in = ST_DONE;
         ST_RD_ADDR: state_in = ST_RD_MEM;
         ST_RD_MEM:  state_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + AW'(1);
         end
      end
   end

   // command register and box walker
   always_ff @(posedge clock) begin
      if (q_pop) begin
         cmd_ff <= q_entry;
         x_ff   <= q_entry.x_lo;
         y_ff   <= q_entry.y_lo;
      end else if (walk_step) begin
         if (x_ff == cmd_ff.x_hi) begin
            x_ff <= cmd_ff.x_lo;
            y_ff <= y_ff + COORD_W'(1);
         end else begin
            x_ff <= x_ff + COORD_W'(1);
         end
      end
   end

   // pixel address and offsets from the circle center
   assign addr_c = AW'(y_ff) * AW'(CANVAS_WIDTH) + AW'(x_ff);
   assign xs     = {{(EDGE_W-COORD_W){1'b0}}, x_ff};
   assign ys     = {{(EDGE_W-COORD_W){1'b0}}, y_ff};
   assign di     = xs - {{(EDGE_W-POS_W){cmd_ff.cx[POS_W-1]}}, cmd_ff.cx};
   assign dj     = ys - {{(EDGE_W-POS_W){cmd_ff.cy[POS_W-1]}}, cmd_ff.cy};
   assign adx    = di[EDGE_W-1] ? SIZE_W'(-di) : di[SIZE_W-1:0];
   assign ady    = dj[EDGE_W-1] ? SIZE_W'(-dj) : dj[SIZE_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
      end else begin
         p1_vld_ff <= walk_step;
      end
   end

   // squares and edge flag, registered
   always_ff @(posedge clock) begin
      p1_addr_ff <= addr_c;
      p1_dx2_ff  <= {{(DIST_W-SIZE_W){1'b0}}, adx} * {{(DIST_W-SIZE_W){1'b0}}, adx};
      p1_dy2_ff  <= {{(DIST_W-SIZE_W){1'b0}}, ady} * {{(DIST_W-SIZE_W){1'b0}}, ady};
      p1_edge_ff <= (xs == cmd_ff.xa) || (xs == cmd_ff.xb) ||
                    (ys == cmd_ff.ya) || (ys == cmd_ff.yb);
   end

   // coverage decision
   assign d2  = {1'b0, p1_dx2_ff} + {1'b0, p1_dy2_ff};
   assign hit = cmd_ff.circle ?
                ((d2 <= {1'b0, cmd_ff.d2_hi}) && (d2 >= {1'b0, cmd_ff.d2_lo})) :
                (!cmd_ff.outline || p1_edge_ff);

   // write port: clearing pass or drawn pixel
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_ff;
         mem_wdata = {1'b0, {(3*COLOR_W){1'b1}}};
      end else begin
         mem_we    = p1_vld_ff && hit;
         mem_waddr = p1_addr_ff;
         mem_wdata = {1'b1, cmd_ff.blue, cmd_ff.green, cmd_ff.red};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         canvas_ff[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= canvas_ff[p1_addr_ff];
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         if (!cmd_ff.is_read) begin
            rsp_status_ff <= STAT_DRAW;
            rsp_pixel_ff  <= '0;
         end else if (cmd_ff.empty) begin
            rsp_status_ff <= STAT_OUTSIDE;
            rsp_pixel_ff  <= '0;
         end else begin
            rsp_status_ff <= STAT_READ;
            rsp_pixel_ff  <= rdata_ff;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-PIXEL_W){1'b0}}, rsp_pixel_ff};

endmodule

// File: src/shape_raster_fill_outline_top.sv
// Shape rasterizer over a CANVAS_WIDTH x CANVAS_HEIGHT RGB canvas with a mark
// bit per pixel. After reset the canvas is swept to white and unmarked, one
// pixel a cycle; req_tready stays low meanwhile.
// After a request is taken into the queue, the back end pops it. A draw then
// walks the canvas-clipped bounding box of its shape one pixel a cycle,
// flushes the coverage stage and loads the response; a draw that covers
// nothing on the canvas and a read outside the canvas go straight to the
// response load; a read inside the canvas registers the address, reads the
// memory and loads the response. The walk rate is set by the single write
// port of the canvas memory, which the box walker feeds. A two-entry command
// queue lets requests be taken while a draw is running, and the response
// register lets the next command start while a response waits.

// ----------------------------------------------------------------------------
// shape_raster_fill_outline_top: rectangle and circle rasterizer
// Intake/classify front, command queue and rasterizing back end.
// ----------------------------------------------------------------------------
module shape_raster_fill_outline_top
   import srfo_pkg::*;
#(
   parameter int CANVAS_WIDTH  = CANVAS_WIDTH_DEF,
   parameter int CANVAS_HEIGHT = CANVAS_HEIGHT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // pos_x[7:0], pos_y[15:8], size_a[22:16], size_b[29:23],
   // red[37:30], green[45:38], blue[53:46], zero[55:54]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // opcode[0], shape_kind[2:1], outline_only[3]
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // pixel_red[7:0], pixel_green[15:8], pixel_blue[23:16],
   // pixel_marked[24], zero[31:25]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // status[1:0]
   output logic [RSP_USER_W-1:0] rsp_tuser
);

   cmd_type push_entry;
   cmd_type pop_entry;
   logic    push;
   logic    q_ready;
   logic    q_valid;
   logic    q_pop;
   logic    clearing;

   srfo_front #(
      .CANVAS_WIDTH  (CANVAS_WIDTH),
      .CANVAS_HEIGHT (CANVAS_HEIGHT)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .clearing   (clearing),
      .q_ready    (q_ready),
      .q_push     (push),
      .q_entry    (push_entry)
   );

   srfo_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .in_ready   (q_ready),
      .pop        (q_pop),
      .pop_entry  (pop_entry),
      .out_valid  (q_valid)
   );

   srfo_back #(
      .CANVAS_WIDTH  (CANVAS_WIDTH),
      .CANVAS_HEIGHT (CANVAS_HEIGHT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_entry    (pop_entry),
      .q_pop      (q_pop),
      .clearing   (clearing),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// File: src/srfo_checker.sv
// ----------------------------------------------------------------------------
// srfo_checker: port-level checks of the shape rasterizer
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module srfo_checker
   import srfo_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [RSP_USER_W-1:0] rsp_tuser
);

   // no request taken in the cycle after reset, the clearing pass runs
   a_clear_blocks: assert property (@(posedge clock) reset |=> !(req_tvalid && req_tready))
      else $error("request accepted while canvas is clearing");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // only defined status codes
   a_rsp_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == STAT_DRAW || rsp_tuser == STAT_READ ||
                      rsp_tuser == STAT_OUTSIDE))
      else $error("undefined response status");

   // draw and off-canvas responses carry no pixel
   a_rsp_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STAT_READ |-> rsp_tdata == '0)
      else $error("pixel data on a non-read response");

endmodule

bind shape_raster_fill_outline_top srfo_checker u_srfo_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// File: test/shape_raster_fill_outline_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// shape_raster_fill_outline_top_test: self-checking bench for the rasterizer
// Streams draw and read requests into the block and keeps its own copy of the
// canvas to predict every response. Each response is checked in order. The
// run starts with directed cases, then random draws mixed with reads that
// mostly land near the last shape. Both sides idle at random in the first two of three phases.
// ----------------------------------------------------------------------------
module shape_raster_fill_outline_top_test;
   import srfo_pkg::*;

   localparam int CANVAS_W      = CANVAS_WIDTH_DEF;
   localparam int CANVAS_H      = CANVAS_HEIGHT_DEF;
   localparam int CANVAS_PIXELS = CANVAS_W * CANVAS_H;
   localparam int CYCLE_LIMIT   = 10_000_000;
   localparam int SETTLE_CYCLES = 16;
   localparam int BATCH_SIZE    = 190;
   localparam int REPORT_MAX    = 10;

   // one request as the block sees it
   typedef struct {
      logic                     op;
      logic [1:0]               kind;
      logic                     outline;
      logic signed [POS_W-1:0]  px;
      logic signed [POS_W-1:0]  py;
      logic [SIZE_W-1:0]        sa;
      logic [SIZE_W-1:0]        sb;
      logic [COLOR_W-1:0]       red;
      logic [COLOR_W-1:0]       green;
      logic [COLOR_W-1:0]       blue;
   } raster_cmd_type;

   // one response
   typedef struct {
      logic [1:0]         status;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
      logic               marked;
   } pixel_rsp_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [REQ_USER_W-1:0] req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;

   // shadow canvas
   logic [COLOR_W-1:0] shadow_red   [CANVAS_PIXELS];
   logic [COLOR_W-1:0] shadow_green [CANVAS_PIXELS];
   logic [COLOR_W-1:0] shadow_blue  [CANVAS_PIXELS];
   logic               shadow_mark  [CANVAS_PIXELS];

   raster_cmd_type pending_cmds [$];
   pixel_rsp_type  expected_rsp [$];
   raster_cmd_type cur_cmd;
   pixel_rsp_type  want_rsp;
   pixel_rsp_type  got_rsp;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int error_count   = 0;
   int rsp_count     = 0;
   int cycle_count   = 0;
   int last_x        = 0;
   int last_y        = 0;

   shape_raster_fill_outline_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // paint one pixel of the shadow canvas, skipping off-canvas spots
   function automatic void paint_pixel(int x, int y, raster_cmd_type c);
      int idx;
      if (x < 0 || y < 0 || x >= CANVAS_W || y >= CANVAS_H) return;
      idx = y * CANVAS_W + x;
      shadow_red[idx]   = c.red;
      shadow_green[idx] = c.green;
      shadow_blue[idx]  = c.blue;
      shadow_mark[idx]  = 1'b1;
   endfunction

   function automatic void paint_box(int w, int h, raster_cmd_type c);
      for (int i = 0; i < w; i++)
         for (int j = 0; j < h; j++)
            if (!c.outline || i == 0 || i == w - 1 || j == 0 || j == h - 1)
               paint_pixel(int'(c.px) + i, int'(c.py) + j, c);
   endfunction

   // apply one request to the shadow canvas and work out its response
   function automatic pixel_rsp_type canvas_response(raster_cmd_type c);
      pixel_rsp_type rsp;
      int x, y, rad, hi, lo, d2, idx;
      rsp = '{status: STAT_DRAW, red: '0, green: '0, blue: '0, marked: 1'b0};
      x = c.px;
      y = c.py;
      if (c.op == OP_READ) begin
         if (x < 0 || y < 0 || x >= CANVAS_W || y >= CANVAS_H) begin
            rsp.status = STAT_OUTSIDE;
         end else begin
            idx        = y * CANVAS_W + x;
            rsp.status = STAT_READ;
            rsp.red    = shadow_red[idx];
            rsp.green  = shadow_green[idx];
            rsp.blue   = shadow_blue[idx];
            rsp.marked = shadow_mark[idx];
         end
         return rsp;
      end
      case (c.kind)
         SHAPE_SQUARE: begin
            paint_box(c.sa, c.sa, c);
         end
         SHAPE_RECT: begin
            paint_box(c.sa, c.sb, c);
         end
         SHAPE_CIRCLE: begin
            rad = c.sa;
            hi  = rad * rad + rad;
            lo  = rad * rad - rad + 1;
            for (int di = -rad; di <= rad; di++)
               for (int dj = -rad; dj <= rad; dj++) begin
                  d2 = di * di + dj * dj;
                  if (d2 <= hi && !(c.outline && rad >= 1 && d2 < lo))
                     paint_pixel(x + di, y + dj, c);
               end
         end
         default: begin
         end
      endcase
      return rsp;
   endfunction

   function automatic void add_cmd(logic op, logic [1:0] kind, logic outline, int x, int y,
                                   int a, int b, logic [23:0] rgb);
      raster_cmd_type c;
      c.op      = op;
      c.kind    = kind;
      c.outline = outline;
      c.px      = POS_W'(x);
      c.py      = POS_W'(y);
      c.sa      = SIZE_W'(a);
      c.sb      = SIZE_W'(b);
      c.red     = rgb[23:16];
      c.green   = rgb[15:8];
      c.blue    = rgb[7:0];
      pending_cmds.insert(pending_cmds.size(), c);
   endfunction

   // random request: reads mostly near the last shape, draws mostly small
   function automatic raster_cmd_type random_cmd();
      raster_cmd_type c;
      int pick;
      c.op      = OP_DRAW;
      c.kind    = 2'($urandom);
      c.outline = 1'($urandom);
      c.px      = POS_W'($urandom);
      c.py      = POS_W'($urandom);
      c.sa      = SIZE_W'($urandom);
      c.sb      = SIZE_W'($urandom);
      c.red     = COLOR_W'($urandom);
      c.green   = COLOR_W'($urandom);
      c.blue    = COLOR_W'($urandom);
      pick      = $urandom_range(99);
      if (pick < 45) begin
         c.op = OP_READ;
         if (pick < 30) begin
            c.px = POS_W'(last_x + int'($urandom_range(20)) - 4);
            c.py = POS_W'(last_y + int'($urandom_range(20)) - 4);
         end else if (pick < 40) begin
            c.px = POS_W'($urandom_range(CANVAS_W - 1));
            c.py = POS_W'($urandom_range(CANVAS_H - 1));
         end
      end else begin
         c.kind = ($urandom_range(99) < 5) ? SHAPE_NONE : 2'($urandom_range(2));
         if ($urandom_range(99) < 85) begin
            c.px = POS_W'(int'($urandom_range(CANVAS_W + 20)) - 12);
            c.py = POS_W'(int'($urandom_range(CANVAS_H + 20)) - 12);
         end
         c.sa   = ($urandom_range(99) < 10) ? SIZE_W'($urandom) : SIZE_W'($urandom_range(16));
         c.sb   = ($urandom_range(99) < 10) ? SIZE_W'($urandom) : SIZE_W'($urandom_range(16));
         last_x = c.px;
         last_y = c.py;
      end
      return c;
   endfunction

   task automatic wait_drained();
      while (pending_cmds.size() != 0 || req_tvalid || expected_rsp.size() != 0)
         @(negedge clock);
   endtask

   // request driver: predicts on acceptance, then offers the next request
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_rsp.insert(expected_rsp.size(), canvas_response(cur_cmd));
         end
         if (!req_tvalid || req_tready) begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               cur_cmd    = pending_cmds.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {2'b00, cur_cmd.blue, cur_cmd.green, cur_cmd.red,
                              cur_cmd.sb, cur_cmd.sa, cur_cmd.py, cur_cmd.px};
               req_tuser  <= {cur_cmd.outline, cur_cmd.kind, cur_cmd.op};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor with random back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_count++;
            got_rsp.status = rsp_tuser[1:0];
            got_rsp.red    = rsp_tdata[7:0];
            got_rsp.green  = rsp_tdata[15:8];
            got_rsp.blue   = rsp_tdata[23:16];
            got_rsp.marked = rsp_tdata[24];
            if (expected_rsp.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_MAX)
                  $display("response %0d arrived with none pending: status %0d",
                           rsp_count, got_rsp.status);
            end else begin
               want_rsp = expected_rsp.pop_front();
               if (got_rsp.status != want_rsp.status || got_rsp.red != want_rsp.red ||
                   got_rsp.green != want_rsp.green || got_rsp.blue != want_rsp.blue ||
                   got_rsp.marked != want_rsp.marked) begin
                  error_count++;
                  if (error_count <= REPORT_MAX)
                     $display({"response %0d mismatch: expected status %0d rgb %02x %02x %02x ",
                               "mark %0d, got status %0d rgb %02x %02x %02x mark %0d"},
                              rsp_count, want_rsp.status, want_rsp.red, want_rsp.green,
                              want_rsp.blue, want_rsp.marked, got_rsp.status, got_rsp.red,
                              got_rsp.green, got_rsp.blue, got_rsp.marked);
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // stimulus sequence
   initial begin
      foreach (shadow_red[i]) begin
         shadow_red[i]   = 8'hff;
         shadow_green[i] = 8'hff;
         shadow_blue[i]  = 8'hff;
         shadow_mark[i]  = 1'b0;
      end
      send_idle_pct = 23;
      recv_idle_pct = 46;

      // fresh canvas reads white and unmarked
      add_cmd(OP_READ, SHAPE_SQUARE, 1'b0, 0, 0, 0, 0, 24'h0);
      add_cmd(OP_READ, SHAPE_CIRCLE, 1'b1, CANVAS_W - 1, CANVAS_H - 1, 127, 127, 24'hffffff);
      // reads off the canvas
      add_cmd(OP_READ, SHAPE_SQUARE, 1'b0, -1, 0, 0, 0, 24'h0);
      add_cmd(OP_READ, SHAPE_SQUARE, 1'b0, CANVAS_W, 5, 0, 0, 24'h0);
      add_cmd(OP_READ, SHAPE_NONE, 1'b1, 127, -128, 127, 127, 24'hffffff);
      // filled square
      add_cmd(OP_DRAW, SHAPE_SQUARE, 1'b0, 2, 2, 3, 9, 24'h123456);
      add_cmd(OP_READ, SHAPE_SQUARE, 1'b0, 2, 2, 0, 0, 24'h0);
      add_cmd(OP_READ, SHAPE_SQUARE, 1'b0, 4, 4, 0, 0, 24'h0);
      // zero sizes and the unused shape kind draw nothing
      add_cmd(OP_DRAW, SHAPE_SQUARE, 1'b0, 20, 20, 0, 5, 24'h00ff00);
      add_cmd(OP_DRAW, SHAPE_RECT, 1'b0, 20, 20, 0, 5, 24'h00ff00);
      add_cmd(OP_DRAW, SHAPE_RECT, 1'b1, 20, 20, 5, 0, 24'h00ff00);
      add_cmd(OP_DRAW, SHAPE_NONE, 1'b0, 20, 20, 10, 10, 24'h00ff00);
      add_cmd(OP_READ, SHAPE_SQUARE, 1'b0, 20, 20, 0, 0, 24'h0);
      // outlined rectangle keeps its interior, draws the far edges
      add_cmd(OP_DRAW, SHAPE_RECT, 1'b1, 10, 10, 6, 4, 24'ha5c3e1);
      add_cmd(OP_READ, SHAPE_SQUARE, 1'b0, 12, 11, 0, 0, 24'h0);
      add_cmd(OP_READ, SHAPE_SQUARE, 1'b0, 15, 13, 0, 0, 24'h0);
      // zero radius circle is the center pixel only
      add_cmd(OP_DRAW, SHAPE_CIRCLE, 1'b1, 30, 30, 0, 0, 24'h010203);
      add_cmd(OP_READ, SHAPE_SQUARE, 1'b0, 30, 30, 0, 0, 24'h0);
      add_cmd(OP_READ, SHAPE_SQUARE, 1'b0, 31, 30, 0, 0, 24'h0);
      // outlined circle leaves its center blank
      add_cmd(OP_DRAW, SHAPE_CIRCLE, 1'b1, 40, 40, 5, 0, 24'h800080);
      add_cmd(OP_READ, SHAPE_SQUARE, 1'b0, 40, 40, 0, 0, 24'h0);
      add_cmd(OP_READ, SHAPE_SQUARE, 1'b0, 45, 40, 0, 0, 24'h0);
      // extremes: largest circle from the far corner, largest box off canvas
      add_cmd(OP_DRAW, SHAPE_CIRCLE, 1'b0, 127, 127, 127, 127, 24'h000000);
      add_cmd(OP_DRAW, SHAPE_RECT, 1'b1, -128, -128, 127, 127, 24'hffffff);
      add_cmd(OP_READ, SHAPE_SQUARE, 1'b0, CANVAS_W - 1, CANVAS_H - 1, 0, 0, 24'h0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // sender holds off until every response is back between phases
      wait_drained();
      for (int n = 0; n < BATCH_SIZE; n++) pending_cmds.insert(pending_cmds.size(), random_cmd());
      wait_drained();
      send_idle_pct = 46;
      recv_idle_pct = 23;
      for (int n = 0; n < BATCH_SIZE; n++) pending_cmds.insert(pending_cmds.size(), random_cmd());
      wait_drained();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int n = 0; n < BATCH_SIZE; n++) pending_cmds.insert(pending_cmds.size(), random_cmd());
      wait_drained();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_rsp.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
